[hdl/float32_adder_macros.svh]
// assertion helpers used by the adder top level
`ifndef FLOAT32_ADDER_MACROS_SVH
`define FLOAT32_ADDER_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define FADD_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequence is sampled a fixed pipeline depth later
`define FADD_LATER(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##5 (cons)) \
		else $error(msg);

`endif

[hdl/fadd_pkg.sv]
// ----------------------------------------------------------------------------
// fadd_pkg
// shared constants and stage control type of the single-precision adder
// ----------------------------------------------------------------------------
package fadd_pkg;

	localparam logic [31:0] EXP_MASK  = 32'h7f80_0000;
	localparam logic [31:0] FRAC_MASK = 32'h007f_ffff;
	localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
	localparam logic [31:0] POS_INF   = 32'h7f80_0000;
	localparam logic [31:0] NEG_INF   = 32'hff80_0000;
	localparam logic [31:0] INF_DIFF  = 32'hffc0_0000;
	localparam logic [7:0]  MAX_GAP   = 8'd24;
	localparam int          FRAC_BITS = 23;
	localparam int          SUM_W     = 50;
	localparam int          MAG_W     = 49;

	// control travelling beside each stage's data
	typedef struct packed {
		logic        vld;
		logic        byp;
		logic [31:0] byp_val;
	} ctl_t;

endpackage

[hdl/fadd_align.sv]
// ----------------------------------------------------------------------------
// fadd_align
// special-case screening, operand ordering, alignment shift and signed add
// ----------------------------------------------------------------------------
module fadd_align (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	input  logic [31:0]                 op_a,
	input  logic [31:0]                 op_b,
	output fadd_pkg::ctl_t              ctl_s2,
	output logic [fadd_pkg::SUM_W-1:0]  sum_s2,
	output logic [7:0]                  be_s2
);

	logic        nan_a, nan_b, zero_a, zero_b, swp;
	logic [31:0] big, sml;
	logic [7:0]  e_big, e_sml, eb1, es1, diff;
	logic [23:0] m_big, m_sml;
	fadd_pkg::ctl_t ctl_c, ctl_s1;
	logic        sa_s1, sb_s1;
	logic [23:0] am_s1, bm_s1;
	logic [4:0]  diff_s1;
	logic [7:0]  be_s1;
	logic [fadd_pkg::SUM_W-1:0] ash, aterm, bterm;

	always_comb begin
		nan_a  = ((op_a & fadd_pkg::EXP_MASK) == fadd_pkg::EXP_MASK)
			&& ((op_a & fadd_pkg::FRAC_MASK) != 32'd0);
		nan_b  = ((op_b & fadd_pkg::EXP_MASK) == fadd_pkg::EXP_MASK)
			&& ((op_b & fadd_pkg::FRAC_MASK) != 32'd0);
		zero_a = (op_a == 32'd0) || (op_a == fadd_pkg::SIGN_BIT);
		zero_b = (op_b == 32'd0) || (op_b == fadd_pkg::SIGN_BIT);
		swp    = op_b[30:23] > op_a[30:23];
		big    = swp ? op_b : op_a;
		sml    = swp ? op_a : op_b;
		e_big  = big[30:23];
		e_sml  = sml[30:23];
		eb1    = (e_big == 8'd0) ? 8'd1 : e_big;
		es1    = (e_sml == 8'd0) ? 8'd1 : e_sml;
		m_big  = {(e_big != 8'd0), big[22:0]};
		m_sml  = {(e_sml != 8'd0), sml[22:0]};
		diff   = eb1 - es1;

		ctl_c.vld     = in_vld;
		ctl_c.byp     = 1'b1;
		ctl_c.byp_val = 32'd0;
		if (nan_a) begin
			ctl_c.byp_val = op_a;
		end else if (nan_b) begin
			ctl_c.byp_val = op_b;
		end else if (op_a == 32'd0 && op_b == fadd_pkg::SIGN_BIT) begin
			ctl_c.byp_val = 32'd0;
		end else if (zero_a) begin
			ctl_c.byp_val = op_b;
		end else if (zero_b) begin
			ctl_c.byp_val = op_a;
		end else if ((op_a == fadd_pkg::POS_INF && op_b == fadd_pkg::NEG_INF)
			|| (op_b == fadd_pkg::POS_INF && op_a == fadd_pkg::NEG_INF)) begin
			ctl_c.byp_val = fadd_pkg::INF_DIFF;
		end else if (diff > fadd_pkg::MAX_GAP) begin
			ctl_c.byp_val = big;
		end else begin
			ctl_c.byp = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_c;
		end
	end

	always_ff @(posedge clk) begin
		sa_s1          <= big[31];
		sb_s1          <= sml[31];
		am_s1          <= m_big;
		bm_s1          <= m_sml;
		diff_s1        <= diff[4:0];
		be_s1          <= es1;
	end

	// align the larger operand onto the smaller one's scale, then add signed
	always_comb begin
		ash   = {{(fadd_pkg::SUM_W-24){1'b0}}, am_s1} << diff_s1;
		aterm = sa_s1 ? (~ash + 1'b1) : ash;
		bterm = {{(fadd_pkg::SUM_W-24){1'b0}}, bm_s1};
		bterm = sb_s1 ? (~bterm + 1'b1) : bterm;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2         <= aterm + bterm;
		be_s2          <= be_s1;
	end

endmodule

[hdl/fadd_norm.sv]
// ----------------------------------------------------------------------------
// fadd_norm
// magnitude, leading-one search and normalization with round decision
// ----------------------------------------------------------------------------
module fadd_norm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fadd_pkg::ctl_t              ctl_s2,
	input  logic [fadd_pkg::SUM_W-1:0]  sum_s2,
	input  logic [7:0]                  be_s2,
	output fadd_pkg::ctl_t              ctl_s4,
	output logic                        sig_s4,
	output logic [23:0]                 norm_s4,
	output logic signed [10:0]          se_s4,
	output logic                        rnd_s4
);

	logic [fadd_pkg::SUM_W-1:0] neg;
	logic [fadd_pkg::MAG_W-1:0] mag, mask;
	logic [5:0]  msb, k;
	fadd_pkg::ctl_t ctl_c, ctl_s3;
	logic [fadd_pkg::MAG_W-1:0] mag_s3;
	logic [5:0]  msb_s3;
	logic        sig_s3;
	logic [7:0]  be_s3;
	logic [23:0] norm;
	logic        rb, sticky, rnd;
	logic signed [10:0] se;

	always_comb begin
		neg = ~sum_s2 + 1'b1;
		mag = sum_s2[fadd_pkg::SUM_W-1] ? neg[fadd_pkg::MAG_W-1:0]
			: sum_s2[fadd_pkg::MAG_W-1:0];
		msb = 6'd0;
		for (int i = 0; i < fadd_pkg::MAG_W; i++) begin
			if (mag[i]) msb = 6'(i);
		end
		ctl_c = ctl_s2;
		// exact cancellation gives plus zero
		if (!ctl_s2.byp && mag == '0) begin
			ctl_c.byp     = 1'b1;
			ctl_c.byp_val = 32'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_c;
		end
	end

	always_ff @(posedge clk) begin
		mag_s3         <= mag;
		msb_s3         <= msb;
		sig_s3         <= sum_s2[fadd_pkg::SUM_W-1];
		be_s3          <= be_s2;
	end

	always_comb begin
		se = $signed({3'b000, be_s3}) + $signed({5'b00000, msb_s3}) - 11'sd23;
		k  = msb_s3 - 6'(fadd_pkg::FRAC_BITS);
		mask = '0;
		rb = 1'b0;
		sticky = 1'b0;
		rnd = 1'b0;
		if (msb_s3 > 6'(fadd_pkg::FRAC_BITS)) begin
			norm   = 24'(mag_s3 >> k);
			rb     = |((mag_s3 >> (k - 6'd1)) & {{(fadd_pkg::MAG_W-1){1'b0}}, 1'b1});
			mask   = ({{(fadd_pkg::MAG_W-1){1'b0}}, 1'b1} << (k - 6'd1))
				- {{(fadd_pkg::MAG_W-1){1'b0}}, 1'b1};
			sticky = |(mag_s3 & mask);
			rnd    = rb & (sticky | norm[0]);
		end else begin
			norm = 24'(mag_s3 << (6'(fadd_pkg::FRAC_BITS) - msb_s3));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s4 <= '0;
		end else begin
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		sig_s4         <= sig_s3;
		norm_s4        <= norm;
		se_s4          <= se;
		rnd_s4         <= rnd;
	end

endmodule

[hdl/fadd_round.sv]
// ----------------------------------------------------------------------------
// fadd_round
// rounding, underflow into denormals, overflow to infinity, result packing
// ----------------------------------------------------------------------------
module fadd_round (
	input  logic                clk,
	input  logic                arst_n,
	input  fadd_pkg::ctl_t      ctl_s4,
	input  logic                sig_s4,
	input  logic [23:0]         norm_s4,
	input  logic signed [10:0]  se_s4,
	input  logic                rnd_s4,
	output logic                vld_s5,
	output logic [31:0]         sum_s5
);

	logic [24:0] r;
	logic [23:0] m;
	logic [7:0]  e;
	logic [4:0]  sh;
	logic [31:0] res;

	always_comb begin
		r   = {1'b0, norm_s4} + {24'd0, rnd_s4};
		m   = r[24] ? r[24:1] : r[23:0];
		e   = r[24] ? (se_s4[7:0] + 8'd1) : se_s4[7:0];
		sh  = 5'(11'sd1 - se_s4);
		res = {sig_s4, e, m[22:0]};
		if (ctl_s4.byp) begin
			res = ctl_s4.byp_val;
		end else if (se_s4 <= 11'sd0) begin
			// underflow truncates into a denormal
			res = {sig_s4, 31'(norm_s4 >> sh)};
		end else if (se_s4 >= 11'sd255) begin
			res = {sig_s4, 31'd0} | fadd_pkg::POS_INF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= ctl_s4.vld;
		end
	end

	always_ff @(posedge clk) begin
		sum_s5 <= res;
	end

endmodule

[hdl/float32_adder.sv]
// ----------------------------------------------------------------------------
// float32_adder
// single-precision adder, five pipeline stages, one request per cycle
// ----------------------------------------------------------------------------
// channel   ports              handshake
// request   op_a, op_b         start high while busy low
// result    sum                done high for one cycle
//
// a request can enter every cycle; its result is registered through each stage below
// the stages in order: screen, align-add, leading one, normalize, round
// busy never rises since no stage holds back
// reset clears only the stage control; data registers are not reset
// the receiver cannot stall, so no back-pressure path exists
// ----------------------------------------------------------------------------
`include "float32_adder_macros.svh"

module float32_adder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] op_a,
	input  logic [31:0] op_b,
	output logic        done,
	output logic [31:0] sum
);

	fadd_pkg::ctl_t ctl_s2, ctl_s4;
	logic [fadd_pkg::SUM_W-1:0] sum_s2;
	logic [7:0]  be_s2;
	logic        sig_s4, rnd_s4;
	logic [23:0] norm_s4;
	logic signed [10:0] se_s4;
	logic        nan_out;

	assign busy = 1'b0;

	// opposite infinities give the one nan not copied from an operand
	assign nan_out = done && sum[30:23] == 8'hff && sum[22:0] != 23'd0
		&& sum != fadd_pkg::INF_DIFF;

	fadd_align u_align (
		.clk    (clk),
		.arst_n (arst_n),
		.in_vld (start),
		.op_a   (op_a),
		.op_b   (op_b),
		.ctl_s2 (ctl_s2),
		.sum_s2 (sum_s2),
		.be_s2  (be_s2)
	);

	fadd_norm u_norm (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s2  (ctl_s2),
		.sum_s2  (sum_s2),
		.be_s2   (be_s2),
		.ctl_s4  (ctl_s4),
		.sig_s4  (sig_s4),
		.norm_s4 (norm_s4),
		.se_s4   (se_s4),
		.rnd_s4  (rnd_s4)
	);

	fadd_round u_round (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s4  (ctl_s4),
		.sig_s4  (sig_s4),
		.norm_s4 (norm_s4),
		.se_s4   (se_s4),
		.rnd_s4  (rnd_s4),
		.vld_s5  (done),
		.sum_s5  (sum)
	);

	`FADD_LATER(a_req_done, start, done, "request did not produce a result")
	`FADD_LATER(a_no_spurious, !start, !done, "result without a request")
	`FADD_IMPLIES(a_nan_source, nan_out, sum == $past(op_a, 5) || sum == $past(op_b, 5),
		"nan result not taken from an operand")

endmodule

[bench/tb_float32_adder.sv]
// ----------------------------------------------------------------------------
// tb_float32_adder
// checks the single-precision adder against a bit-exact model of its rules:
// directed special values (nan, zero, infinity, denormal, wide gap,
// cancellation, overflow, underflow) then random operand pairs with random gaps
// ----------------------------------------------------------------------------
module tb_float32_adder;

	localparam int LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] op_a;
	logic [31:0] op_b;
	logic        done;
	logic [31:0] sum;

	int cycles;
	int n_sent;

	float32_adder dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.op_a(op_a), .op_b(op_b), .done(done), .sum(sum)
	);

	function automatic logic fp_is_nan(logic [31:0] v);
		return (v & fadd_pkg::EXP_MASK) == fadd_pkg::EXP_MASK
			&& (v & fadd_pkg::FRAC_MASK) != 0;
	endfunction

	// predicted sum of two single-precision words
	function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
		logic [31:0] t, ae, be, diff;
		logic [63:0] am, bm, sm, orig, x, half;
		logic        sig;
		int          msb, k;
		longint      se;
		if (fp_is_nan(a)) return a;
		if (fp_is_nan(b)) return b;
		if (a == 0 && b == fadd_pkg::SIGN_BIT) return 0;
		if (a == 0 || a == fadd_pkg::SIGN_BIT) return b;
		if (b == 0 || b == fadd_pkg::SIGN_BIT) return a;
		if ((a == fadd_pkg::POS_INF && b == fadd_pkg::NEG_INF)
			|| (b == fadd_pkg::POS_INF && a == fadd_pkg::NEG_INF))
			return fadd_pkg::INF_DIFF;
		ae = (a >> 23) & 32'hff;
		be = (b >> 23) & 32'hff;
		if (be > ae) begin
			t = ae; ae = be; be = t;
			t = a; a = b; b = t;
		end
		if (ae == 0) begin
			ae = 1; am = {32'd0, a & fadd_pkg::FRAC_MASK};
		end else
			am = {32'd0, a & fadd_pkg::FRAC_MASK} + 64'h80_0000;
		if (be == 0) begin
			be = 1; bm = {32'd0, b & fadd_pkg::FRAC_MASK};
		end else
			bm = {32'd0, b & fadd_pkg::FRAC_MASK} + 64'h80_0000;
		diff = ae - be;
		if (diff > 32'(fadd_pkg::MAX_GAP)) return a;
		am = am << diff;
		if (a[31]) am = -am;
		if (b[31]) bm = -bm;
		sm = am + bm;
		if (sm == 0) return 0;
		sig = sm[63];
		if (sig) sm = -sm;
		orig = sm;
		msb = 63;
		while (msb > 0 && (sm >> msb) == 0) msb--;
		se = longint'(be) + msb - fadd_pkg::FRAC_BITS;
		if (msb > fadd_pkg::FRAC_BITS) sm = sm >> (msb - fadd_pkg::FRAC_BITS);
		else sm = sm << (fadd_pkg::FRAC_BITS - msb);
		if (se <= 0)
			return {sig, 31'd0} + 32'(sm >> (1 - se));
		if (se >= 255)
			return {sig, 31'd0} + fadd_pkg::POS_INF;
		if (msb > fadd_pkg::FRAC_BITS) begin
			k = msb - fadd_pkg::FRAC_BITS;
			x = orig & ((64'd1 << k) - 1);
			half = 64'd1 << (k - 1);
			if (x > half || (x == half && sm[0])) sm = sm + 1;
		end
		if ((sm >> 23) > 1) begin
			sm = sm >> 1;
			se++;
		end
		return {sig, 31'd0} + (32'(se) << 23) + (32'(sm) & fadd_pkg::FRAC_MASK);
	endfunction

	class sum_board;
		logic [31:0] pending[$];
		int n_err;
		int n_ok;

		function void note_request(logic [31:0] a, logic [31:0] b);
			pending.push_back(fp_add(a, b));
		endfunction

		function void check_sum(logic [31:0] got);
			logic [31:0] want;
			if (pending.size() == 0) begin
				$error("sum 0x%08h arrived with no request outstanding", got);
				n_err++;
				return;
			end
			want = pending.pop_front();
			if (want !== got) begin
				$error("sum mismatch: expected 0x%08h actual 0x%08h", want, got);
				n_err++;
			end else
				n_ok++;
		endfunction
	endclass

	sum_board board;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAILURE");
			$finish;
		end
	end

	// results and accepted requests are sampled on the same edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) board.note_request(op_a, op_b);
			if (done) board.check_sum(sum);
		end
	end

	task automatic send(logic [31:0] a, logic [31:0] b);
		start <= 1;
		op_a  <= a;
		op_b  <= b;
		@(posedge clk);
		while (busy) @(posedge clk);
		n_sent++;
	endtask

	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
		if (n > 0) begin
			start <= 0;
			op_a  <= $urandom;
			op_b  <= $urandom;
			repeat (n) @(posedge clk);
		end
	endtask

	// random operand, biased toward edges of the exponent range and toward near_exp
	function automatic logic [31:0] rand_word(logic [7:0] near_exp);
		logic [7:0] e;
		case ($urandom_range(0, 9))
			0: e = 8'd0;
			1: e = 8'hff;
			2: e = 8'($urandom_range(0, 255));
			3: e = ($urandom_range(0, 1)) ? 8'd254 : 8'd1;
			default: e = near_exp + 8'($urandom_range(0, 26)) - 8'd13;
		endcase
		return {1'($urandom), e, 23'($urandom)};
	endfunction

	initial begin
		logic [31:0] a;
		logic [7:0]  e;
		logic [31:0] dir[24][2];
		board  = new();
		cycles = 0;
		n_sent = 0;
		arst_n = 0;
		start  = 0;
		op_a   = 0;
		op_b   = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		dir = '{
			'{32'h7fc0_0001, 32'hffc0_0002}, '{32'h3f80_0000, 32'hff80_0001},
			'{32'h0000_0000, 32'h8000_0000}, '{32'h8000_0000, 32'h0000_0000},
			'{32'h8000_0000, 32'h4120_0000}, '{32'hc120_0000, 32'h0000_0000},
			'{32'h7f80_0000, 32'hff80_0000}, '{32'hff80_0000, 32'h7f80_0000},
			'{32'h7f80_0000, 32'h7f80_0000}, '{32'hff80_0000, 32'h3f80_0000},
			'{32'h4b80_0000, 32'h3f80_0000}, '{32'h3f80_0000, 32'h4c00_0000},
			'{32'h3f80_0000, 32'hbf80_0000}, '{32'h7f7f_ffff, 32'h7f7f_ffff},
			'{32'h7f7f_ffff, 32'h7380_0000}, '{32'h0080_0000, 32'h8070_0000},
			'{32'h0000_0001, 32'h0000_0001}, '{32'h007f_ffff, 32'h0000_0001},
			'{32'h8000_0001, 32'h807f_ffff}, '{32'h3f80_0001, 32'h3380_0000},
			'{32'h3f80_0000, 32'h3380_0000}, '{32'hffff_ffff, 32'h0000_0000},
			'{32'h4000_0000, 32'hbfff_ffff}, '{32'hfffe_0000, 32'h7ffe_0000}
		};
		foreach (dir[i]) begin
			send(dir[i][0], dir[i][1]);
			idle_gap();
		end

		repeat (500) begin
			e = 8'($urandom_range(0, 255));
			a = rand_word(e);
			case ($urandom_range(0, 7))
				0: send(a, {~a[31], a[30:0]} ^ 32'($urandom_range(0, 3)));
				1: send($urandom, $urandom);
				default: send({a[31], e, a[22:0]}, rand_word(e));
			endcase
			if ($urandom_range(0, 3) == 0) idle_gap();
		end
		start <= 0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d requests, %0d sums matched, %0d mismatches",
			n_sent, board.n_ok, board.n_err);
		$display("covered nan, zero, infinity, denormal, gap, overflow and rounding cases");
		if (board.n_err == 0 && board.pending.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
